// ===== rtl/core/sfrr_pkg.sv =====
package sfrr_pkg;

	// Field widths
	localparam int CH_W   = 2;
	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int POS_W  = 4;

	// Default number of link channels
	localparam int CHANNELS_DEF = 2;

	// Frame bytes and CRC constants
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
	localparam logic [BYTE_W-1:0] FN_READ   = 8'h03;
	localparam logic [BYTE_W-1:0] FN_WRITE1 = 8'h06;
	localparam logic [BYTE_W-1:0] FN_WRITEN = 8'h10;
	localparam logic [WORD_W-1:0] CRC_POLY  = 16'hA001;
	localparam logic [WORD_W-1:0] CRC_INIT  = 16'hFFFF;

	// Frame positions
	localparam logic [POS_W-1:0] POS_IDLE    = 4'd0;
	localparam logic [POS_W-1:0] POS_SYNC    = 4'd1;
	localparam logic [POS_W-1:0] POS_HDR0    = 4'd2;
	localparam logic [POS_W-1:0] POS_HDR_END = 4'd5;
	localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd6;
	localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd7;

	typedef enum logic [1:0] {
		EV_READ    = 2'd0,
		EV_WRITE1  = 2'd1,
		EV_CRC_ERR = 2'd2,
		EV_WRITEN  = 2'd3
	} ev_t;

	// Receive state of one channel
	typedef struct packed {
		logic [POS_W-1:0]    pos;
		logic [BYTE_W-1:0]   fcode;
		logic [WORD_W-1:0]   crc;
		logic [2*WORD_W-1:0] hdr;
		logic [BYTE_W-1:0]   crc_lo;
	} chan_state_t;

	// Event produced by one item
	typedef struct packed {
		ev_t               ev;
		logic [CH_W-1:0]   channel;
		logic [WORD_W-1:0] addr;
		logic [WORD_W-1:0] val;
	} result_t;

	// Outcome of one frame step
	typedef struct packed {
		logic    wr_en;
		logic    has_res;
		result_t res;
	} step_ctl_t;

	// Modbus CRC-16 over one byte, reflected, LSB first
	function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] c;
		c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/sfrr_state_bank.sv =====
module sfrr_state_bank #(
	parameter int CHANNELS = sfrr_pkg::CHANNELS_DEF,
	parameter int IDX_W    = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IDX_W-1:0]       rd_idx,
	output sfrr_pkg::chan_state_t  rd_data,
	input  logic                   wr_en,
	input  logic [IDX_W-1:0]       wr_idx,
	input  sfrr_pkg::chan_state_t  wr_data
);
	import sfrr_pkg::*;

	logic [POS_W-1:0]    pos_q    [CHANNELS];
	logic [BYTE_W-1:0]   fcode_q  [CHANNELS];
	logic [WORD_W-1:0]   crc_q    [CHANNELS];
	logic [2*WORD_W-1:0] hdr_q    [CHANNELS];
	logic [BYTE_W-1:0]   crc_lo_q [CHANNELS];

	// Hold frame position per channel, cleared to idle at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++)
				pos_q[i] <= POS_IDLE;
		end else if (wr_en) begin
			pos_q[wr_idx] <= wr_data.pos;
		end
	end

	// Hold frame contents, valid only once written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fcode_q[wr_idx]  <= wr_data.fcode;
			crc_q[wr_idx]    <= wr_data.crc;
			hdr_q[wr_idx]    <= wr_data.hdr;
			crc_lo_q[wr_idx] <= wr_data.crc_lo;
		end
	end

	// Select the state of the channel at hand
	always_comb begin
		rd_data.pos    = pos_q[rd_idx];
		rd_data.fcode  = fcode_q[rd_idx];
		rd_data.crc    = crc_q[rd_idx];
		rd_data.hdr    = hdr_q[rd_idx];
		rd_data.crc_lo = crc_lo_q[rd_idx];
	end

endmodule

// ===== rtl/core/sfrr_frame_step.sv =====
module sfrr_frame_step (
	input  sfrr_pkg::chan_state_t       cur,
	input  logic [sfrr_pkg::BYTE_W-1:0] rx_byte,
	input  logic [sfrr_pkg::CH_W-1:0]   channel,
	output sfrr_pkg::chan_state_t       nxt,
	output sfrr_pkg::step_ctl_t         ctl
);
	import sfrr_pkg::*;

	logic [WORD_W-1:0] crc_upd;
	logic [WORD_W-1:0] rx_crc;
	logic              fn_ok;

	assign crc_upd = crc_feed(cur.crc, rx_byte);
	assign rx_crc  = {rx_byte, cur.crc_lo};
	assign fn_ok   = (rx_byte == FN_READ) || (rx_byte == FN_WRITE1) || (rx_byte == FN_WRITEN);

	// Advance the channel by one byte
	always_comb begin
		nxt             = cur;
		ctl.wr_en       = 1'b1;
		ctl.has_res     = 1'b0;
		ctl.res.ev      = EV_READ;
		ctl.res.channel = channel;
		ctl.res.addr    = cur.hdr[2*WORD_W-1:WORD_W];
		ctl.res.val     = cur.hdr[WORD_W-1:0];
		if (cur.pos == POS_IDLE) begin
			if (rx_byte == SYNC_BYTE) begin
				nxt.crc = crc_feed(CRC_INIT, rx_byte);
				nxt.pos = POS_SYNC;
			end else begin
				ctl.wr_en = 1'b0;
			end
		end else if (cur.pos == POS_SYNC) begin
			if (fn_ok) begin
				nxt.fcode = rx_byte;
				nxt.crc   = crc_upd;
				nxt.hdr   = '0;
				nxt.pos   = POS_HDR0;
			end else begin
				nxt.pos = POS_IDLE;
			end
		end else if (cur.pos > POS_CRC_HI) begin
			nxt.pos = POS_IDLE;
		end else if (cur.fcode == FN_WRITEN) begin
			// Hand off write-multiple, drop the byte
			nxt.pos      = POS_IDLE;
			ctl.has_res  = 1'b1;
			ctl.res.ev   = EV_WRITEN;
			ctl.res.addr = '0;
			ctl.res.val  = '0;
		end else if (cur.fcode != FN_READ && cur.fcode != FN_WRITE1) begin
			nxt.pos = POS_IDLE;
		end else if (cur.pos <= POS_HDR_END) begin
			nxt.crc = crc_upd;
			nxt.hdr = {cur.hdr[2*WORD_W-BYTE_W-1:0], rx_byte};
			nxt.pos = cur.pos + 1'b1;
		end else if (cur.pos == POS_CRC_LO) begin
			nxt.crc_lo = rx_byte;
			nxt.pos    = POS_CRC_HI;
		end else begin
			// Check the CRC and close the frame
			nxt.pos     = POS_IDLE;
			ctl.has_res = 1'b1;
			if (cur.crc != rx_crc)
				ctl.res.ev = EV_CRC_ERR;
			else if (cur.fcode == FN_READ)
				ctl.res.ev = EV_READ;
			else
				ctl.res.ev = EV_WRITE1;
		end
	end

endmodule

// ===== rtl/core/sync_framed_request_receiver_unit.sv =====
// Framed request receiver, one receive state per link channel.
// Input channel: channel (one-based) and rx_byte, moved under in_valid/in_stall.
// Output channel: event_res, event_channel, reg_address, count_or_value, moved
// under out_valid/out_stall. Each accepted item gives zero or one event:
// read request, write single, CRC error or write-multiple handoff. Items on a
// channel of zero or above CHANNELS are dropped without effect.
// Pipeline: an item is registered at the input register, and its frame step
// and the channel state update run from that register; its event is loaded
// into the result register, which drives out_valid.
// Throughput: one item per cycle while no event item is held by out_stall;
// the CRC byte update and the frame step sit combinationally between the
// input register and the result register.
// Reset: all channels return to idle, waiting for the sync byte; the input
// and output registers are emptied.
// Stall: while a result waits under out_stall, items that give no event still
// pass and update their channel; an item that gives an event holds in the
// input register and in_stall rises until the output is taken.
module sync_framed_request_receiver_unit #(
	parameter int CHANNELS = sfrr_pkg::CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [sfrr_pkg::CH_W-1:0]    channel,
	input  logic [sfrr_pkg::BYTE_W-1:0]  rx_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   event_res,
	output logic [sfrr_pkg::CH_W-1:0]    event_channel,
	output logic [sfrr_pkg::WORD_W-1:0]  reg_address,
	output logic [sfrr_pkg::WORD_W-1:0]  count_or_value
);
	import sfrr_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic              valid_s1;
	logic [CH_W-1:0]   channel_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	result_t           res_q;

	logic              ch_ok;
	logic [CH_W-1:0]   ch_m1;
	logic [IDX_W-1:0]  idx;
	chan_state_t       cur_st;
	chan_state_t       nxt_st;
	step_ctl_t         ctl;
	logic              has_res;
	logic              fire_s1;
	logic              in_acc;

	assign ch_ok   = (channel_s1 != '0) && (int'(channel_s1) <= CHANNELS);
	assign ch_m1   = channel_s1 - 1'b1;
	assign idx     = IDX_W'(ch_m1);
	assign has_res = ch_ok && ctl.has_res;
	assign fire_s1 = valid_s1 && !(out_valid_q && out_stall && has_res);
	assign in_stall = valid_s1 && !fire_s1;
	assign in_acc   = in_valid && !in_stall;

	sfrr_state_bank #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (idx),
		.rd_data (cur_st),
		.wr_en   (fire_s1 && ch_ok && ctl.wr_en),
		.wr_idx  (idx),
		.wr_data (nxt_st)
	);

	sfrr_frame_step u_step (
		.cur     (cur_st),
		.rx_byte (byte_s1),
		.channel (channel_s1),
		.nxt     (nxt_st),
		.ctl     (ctl)
	);

	// Track the input register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			channel_s1 <= channel;
			byte_s1    <= rx_byte;
		end
	end

	// Track the result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the event
	always_ff @(posedge clk) begin
		if (fire_s1 && has_res)
			res_q <= ctl.res;
	end

	assign out_valid      = out_valid_q;
	assign event_res      = res_q.ev;
	assign event_channel  = res_q.channel;
	assign reg_address    = res_q.addr;
	assign count_or_value = res_q.val;

endmodule

// ===== rtl/core/sfrr_checker.sv =====
module sfrr_checker #(
	parameter int CHANNELS = sfrr_pkg::CHANNELS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [sfrr_pkg::CH_W-1:0]    channel,
	input logic [sfrr_pkg::BYTE_W-1:0]  rx_byte,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   event_res,
	input logic [sfrr_pkg::CH_W-1:0]    event_channel,
	input logic [sfrr_pkg::WORD_W-1:0]  reg_address,
	input logic [sfrr_pkg::WORD_W-1:0]  count_or_value
);
	import sfrr_pkg::*;

	// Hold a stalled item steady
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) &&
		$stable(event_channel) && $stable(reg_address) && $stable(count_or_value))
		else $error("stalled output item changed");

	// Hold a stalled input item steady
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(channel) && $stable(rx_byte))
		else $error("stalled input item changed");

	// Input backs up only behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// Events come only from valid channels
	a_ev_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_channel != '0 && int'(event_channel) <= CHANNELS)
		else $error("event on invalid channel");

	// Write-multiple handoff carries no words
	a_handoff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_WRITEN |-> reg_address == '0 && count_or_value == '0)
		else $error("handoff event with nonzero words");

endmodule

bind sync_framed_request_receiver_unit sfrr_checker #(.CHANNELS(CHANNELS)) u_sfrr_checker (.*);
